// ===== rtl/core/rdi_pkg.sv =====
package rdi_pkg;

    // Default number of fractional bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int VAL_W = 32;
    localparam int RAD_W = 31;

    // Radius after reset: 1.0 in unsigned Q15.16
    localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;

    // One ray test transaction
    typedef struct packed {
        logic signed [VAL_W-1:0] origin_x;
        logic signed [VAL_W-1:0] origin_y;
        logic signed [VAL_W-1:0] origin_z;
        logic signed [VAL_W-1:0] dir_x;
        logic signed [VAL_W-1:0] dir_y;
        logic signed [VAL_W-1:0] dir_z;
        logic signed [VAL_W-1:0] t_min;
        logic signed [VAL_W-1:0] t_max;
        logic signed [VAL_W-1:0] closest_t;
    } t_ray_in;

    // One hit result transaction
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] hit_t;
        logic signed [VAL_W-1:0] hit_x;
        logic signed [VAL_W-1:0] hit_z;
    } t_hit_out;

endpackage

// ===== rtl/core/rdi_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The ray payload and the quotient sign ride along with each stage.
module rdi_div_pipe #(
    parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [rdi_pkg::VAL_W+FRAC_BITS-1:0] i_num,
    input  logic [rdi_pkg::VAL_W-1:0]      i_den,
    input  logic                           i_neg,
    input  rdi_pkg::t_ray_in               i_side,
    output logic                           o_vld,
    output logic [rdi_pkg::VAL_W+FRAC_BITS-1:0] o_quo,
    output logic                           o_neg,
    output rdi_pkg::t_ray_in               o_side
);

    localparam int NUM_W = rdi_pkg::VAL_W + FRAC_BITS;
    localparam int W     = rdi_pkg::VAL_W;

    // Per-stage registers
    logic                r_vld  [NUM_W];
    logic [W-1:0]        r_rem  [NUM_W];
    logic [NUM_W-1:0]    r_num  [NUM_W];
    logic [W-1:0]        r_den  [NUM_W];
    logic [NUM_W-1:0]    r_quo  [NUM_W];
    logic                r_neg  [NUM_W];
    rdi_pkg::t_ray_in    r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             vld_in;
        logic [W-1:0]     rem_in;
        logic [NUM_W-1:0] num_in;
        logic [W-1:0]     den_in;
        logic [NUM_W-1:0] quo_in;
        logic             neg_in;
        rdi_pkg::t_ray_in side_in;
        logic [W:0]       trial;
        logic [W:0]       diff;
        logic             ge;
        logic [W-1:0]     n_rem;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign neg_in  = i_neg;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign neg_in  = r_neg[k-1];
            assign side_in = r_side[k-1];
        end

        // Shift in the next numerator bit, subtract if it fits
        always_comb begin
            trial = {rem_in, num_in[NUM_W-1-k]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? diff[W-1:0] : trial[W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem[k]  <= n_rem;
            r_num[k]  <= num_in;
            r_den[k]  <= den_in;
            r_quo[k]  <= {quo_in[NUM_W-2:0], ge};
            r_neg[k]  <= neg_in;
            r_side[k] <= side_in;
        end
    end

    assign o_vld  = r_vld[NUM_W-1];
    assign o_quo  = r_quo[NUM_W-1];
    assign o_neg  = r_neg[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

// ===== rtl/core/ray_disk_intersect.sv =====
// Ray / disk intersection in the disk's local frame (disk in y = 0, centered at the
// origin). A ray transaction is accepted whenever start is high; busy is always low, so
// one ray is taken every cycle. Each ray yields exactly one result, flagged by o_done
// for one cycle, in order. A ray passes an input stage, then the divider computing
// t = -origin_y / dir_y (Q16.16 at the default FRAC_BITS) one quotient bit per pipeline
// stage (32 + FRAC_BITS stages), then five stages for saturation, limit checks, hit
// point and radius test. Results cannot be held off. The radius register may be
// written only when no ray is in flight.
module ray_disk_intersect #(
    parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rdi_pkg::t_ray_in              i_ray,
    input  logic                          i_cfg_we,
    input  logic [rdi_pkg::RAD_W-1:0]     i_cfg_wdata,
    output logic                          o_done,
    output rdi_pkg::t_hit_out             o_result
);

    localparam int W     = rdi_pkg::VAL_W;
    localparam int RW    = rdi_pkg::RAD_W;
    localparam int NUM_W = W + FRAC_BITS;
    localparam int LAT   = NUM_W + 6;

    localparam logic [NUM_W-1:0] Q_POS_MAX = {{(NUM_W-W){1'b0}}, 1'b0, {(W-1){1'b1}}};
    localparam logic [NUM_W-1:0] Q_NEG_MAX = {{(NUM_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W-1:0] S_MAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W-1:0] S_MIN = {{(W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat32(input logic signed [2*W-1:0] v);
        logic signed [W-1:0] res;
        if (v > S_MAX) begin
            res = {1'b0, {(W-1){1'b1}}};
        end else if (v < S_MIN) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    assign busy = 1'b0;

    // Radius register and its square
    logic [RW-1:0]   r_radius;
    logic [2*RW-1:0] r_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= rdi_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
        r_rr <= r_radius * r_radius;
    end

    // Input stage: magnitudes and quotient sign
    logic                 r_in_vld;
    rdi_pkg::t_ray_in     r_in_ray;
    logic [NUM_W-1:0]     r_in_num;
    logic [W-1:0]         r_in_den;
    logic                 r_in_neg;
    logic [W-1:0]         oy_mag;
    logic [W-1:0]         dy_mag;

    always_comb begin
        oy_mag = i_ray.origin_y[W-1] ? W'(-i_ray.origin_y) : W'(i_ray.origin_y);
        dy_mag = i_ray.dir_y[W-1]    ? W'(-i_ray.dir_y)    : W'(i_ray.dir_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in_ray <= i_ray;
        r_in_num <= {oy_mag, {FRAC_BITS{1'b0}}};
        r_in_den <= dy_mag;
        r_in_neg <= (!i_ray.origin_y[W-1] && (|i_ray.origin_y)) ^ i_ray.dir_y[W-1];
    end

    // Divider pipeline
    logic             dv_vld;
    logic [NUM_W-1:0] dv_quo;
    logic             dv_neg;
    rdi_pkg::t_ray_in dv_ray;

    rdi_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_num   (r_in_num),
        .i_den   (r_in_den),
        .i_neg   (r_in_neg),
        .i_side  (r_in_ray),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_neg   (dv_neg),
        .o_side  (dv_ray)
    );

    // Stage A: apply sign and saturate t
    logic                r_a_vld;
    rdi_pkg::t_ray_in    r_a_ray;
    logic signed [W-1:0] r_a_t;
    logic signed [W-1:0] n_a_t;

    always_comb begin
        if (dv_neg) begin
            n_a_t = (dv_quo > Q_NEG_MAX) ? {1'b1, {(W-1){1'b0}}} : W'(-dv_quo[W-1:0]);
        end else begin
            n_a_t = (dv_quo > Q_POS_MAX) ? {1'b0, {(W-1){1'b1}}} : dv_quo[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= dv_vld;
        end
        r_a_ray <= dv_ray;
        r_a_t   <= n_a_t;
    end

    // Stage B: limit checks and direction products
    logic                  r_b_vld;
    logic                  r_b_ok;
    logic signed [W-1:0]   r_b_t;
    logic signed [W-1:0]   r_b_ox;
    logic signed [W-1:0]   r_b_oz;
    logic signed [2*W-1:0] r_b_px;
    logic signed [2*W-1:0] r_b_pz;
    logic                  n_b_ok;

    always_comb begin
        n_b_ok = (r_a_ray.dir_y != '0) &&
                 !(r_a_t > r_a_ray.closest_t || r_a_t <= r_a_ray.t_min ||
                   r_a_t > r_a_ray.t_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_ok <= n_b_ok;
        r_b_t  <= r_a_t;
        r_b_ox <= r_a_ray.origin_x;
        r_b_oz <= r_a_ray.origin_z;
        r_b_px <= r_a_ray.dir_x * r_a_t;
        r_b_pz <= r_a_ray.dir_z * r_a_t;
    end

    // Stage C: floor shift, add origin, saturate
    logic                  r_c_vld;
    logic                  r_c_ok;
    logic signed [W-1:0]   r_c_t;
    logic signed [W-1:0]   r_c_x;
    logic signed [W-1:0]   r_c_z;
    logic signed [2*W-1:0] sum_x;
    logic signed [2*W-1:0] sum_z;

    always_comb begin
        sum_x = (r_b_px >>> FRAC_BITS) + $signed({{W{r_b_ox[W-1]}}, r_b_ox});
        sum_z = (r_b_pz >>> FRAC_BITS) + $signed({{W{r_b_oz[W-1]}}, r_b_oz});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_ok <= r_b_ok;
        r_c_t  <= r_b_t;
        r_c_x  <= sat32(sum_x);
        r_c_z  <= sat32(sum_z);
    end

    // Stage D: squares of the hit point coordinates
    logic                  r_d_vld;
    logic                  r_d_ok;
    logic signed [W-1:0]   r_d_t;
    logic signed [W-1:0]   r_d_x;
    logic signed [W-1:0]   r_d_z;
    logic signed [2*W-1:0] r_d_sqx;
    logic signed [2*W-1:0] r_d_sqz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_ok  <= r_c_ok;
        r_d_t   <= r_c_t;
        r_d_x   <= r_c_x;
        r_d_z   <= r_c_z;
        r_d_sqx <= r_c_x * r_c_x;
        r_d_sqz <= r_c_z * r_c_z;
    end

    // Stage E: radius test and output register
    logic            r_done;
    rdi_pkg::t_hit_out r_result;
    logic [2*W-1:0]  sq_sum;
    logic            hit;

    always_comb begin
        sq_sum = $unsigned(r_d_sqx) + $unsigned(r_d_sqz);
        hit    = r_d_ok && (sq_sum <= {{(2*W-2*RW){1'b0}}, r_rr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_d_vld;
        end
        r_result.hit   <= hit;
        r_result.hit_t <= hit ? r_d_t : '0;
        r_result.hit_x <= hit ? r_d_x : '0;
        r_result.hit_z <= hit ? r_d_z : '0;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted ray produces its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("ray result missing at expected latency");

    // A miss reports all-zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.hit) |->
            (o_result.hit_t == '0 && o_result.hit_x == '0 && o_result.hit_z == '0))
        else $error("miss result carries nonzero fields");

    // Results appear only for rays that entered the pipeline
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_d_vld))
        else $error("result strobe without a ray in the last stage");

endmodule
